// ===== hw/rtl/fmtu_pkg.sv =====
// Shared types, constants and helpers for the radix text formatter.
// Used by fmtu_div and format_unsigned_in_base_padded; depends on nothing.
package fmtu_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_CHARS   = 64;
  localparam int MAX_DIGITS  = VALUE_WIDTH;

  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int QW        = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam int CNT_MAX = (MAX_CHARS > VALUE_WIDTH) ? MAX_CHARS : VALUE_WIDTH;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int DIG_AW  = $clog2(MAX_DIGITS);

  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;
  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [6:0] MIN_RESET   = 7'd0;
  localparam logic [7:0] FILL_RESET  = 8'd48;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A    = 8'h41;

  localparam logic [1:0] REG_RADIX = 2'd0;
  localparam logic [1:0] REG_MIN   = 2'd1;
  localparam logic [1:0] REG_FILL  = 2'd2;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [4:0]             divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [3:0]             rem;
  } div_rsp_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0, d};
    end else begin
      return CHAR_A + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

// ===== hw/rtl/format_unsigned_in_base_padded.sv =====
// Top level of the radix text formatter: config registers, sequencer, digit store.
// Depends on fmtu_pkg and fmtu_div.
//
// A value is taken when start is high and busy is low; busy then stays high until
// the last character. Each digit costs one pass of the shared divider and a handoff
// back to the sequencer. Characters come one per out_valid beat, at most one a
// cycle, fill first and then digits most significant first, with out_is_last on the
// final one; the receiver cannot stall them, so each beat must be taken as it comes.
// Registers sit at byte addresses 0 (radix), 4 (min_digits) and 8 (fill_char) and
// are to be written only while busy is low, which the block itself does not enforce.
module format_unsigned_in_base_padded (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_is_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmtu_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_PAD, S_DIG, S_DRAIN} state_t;

  state_t                 state_r;
  logic [4:0]             radix_r;
  logic [6:0]             min_digits_r;
  logic [7:0]             fill_char_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]       ndig_r;
  logic [CNT_W-1:0]       pad_r;
  logic [DIG_AW-1:0]      rd_idx_r;
  logic                   div_start_r;
  logic                   rd_v_r;
  logic                   rd_last_r;
  logic [3:0]             rd_data_r;
  logic                   out_valid_r;
  logic [7:0]             out_char_r;
  logic                   out_last_r;
  logic [3:0]             dig_mem_r [MAX_DIGITS];

  logic [4:0]       eff_radix;
  logic [CNT_W-1:0] want;
  logic [CNT_W-1:0] ndig_inc;
  logic             cfg_wr;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign eff_radix = (radix_r < RADIX_MIN) ? RADIX_MIN :
                     (radix_r > RADIX_MAX) ? RADIX_MAX : radix_r;
  assign want      = (min_digits_r > 7'(MAX_CHARS)) ? CNT_W'(MAX_CHARS)
                                                    : CNT_W'(min_digits_r);
  assign ndig_inc  = ndig_r + 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  assign div_req.start    = div_start_r;
  assign div_req.dividend = val_r;
  assign div_req.divisor  = eff_radix;

  fmtu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RADIX_RESET;
      min_digits_r <= MIN_RESET;
      fill_char_r  <= FILL_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RADIX: radix_r      <= pwdata[4:0];
        REG_MIN:   min_digits_r <= pwdata[6:0];
        REG_FILL:  fill_char_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIX: prdata = {27'b0, radix_r};
      REG_MIN:   prdata = {25'b0, min_digits_r};
      REG_FILL:  prdata = {24'b0, fill_char_r};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (state_r == S_DIV && div_rsp.done) begin
      dig_mem_r[ndig_r[DIG_AW-1:0]] <= div_rsp.rem;
    end
    rd_data_r <= dig_mem_r[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      rd_v_r      <= (state_r == S_DIG);
      rd_last_r   <= (rd_idx_r == '0);
      out_valid_r <= (state_r == S_PAD) || rd_v_r;
      out_char_r  <= (state_r == S_PAD) ? fill_char_r : glyph(rd_data_r);
      out_last_r  <= (state_r != S_PAD) && rd_v_r && rd_last_r;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            val_r       <= in_value[VALUE_WIDTH-1:0];
            ndig_r      <= '0;
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            val_r  <= div_rsp.quotient;
            ndig_r <= ndig_inc;
            if (div_rsp.quotient != '0 && ndig_inc < CNT_W'(MAX_DIGITS)) begin
              div_start_r <= 1'b1;
            end else begin
              rd_idx_r <= ndig_r[DIG_AW-1:0];
              if (want > ndig_inc) begin
                pad_r   <= want - ndig_inc;
                state_r <= S_PAD;
              end else begin
                state_r <= S_DIG;
              end
            end
          end
        end
        S_PAD: begin
          pad_r <= pad_r - 1'b1;
          if (pad_r == CNT_W'(1)) begin
            state_r <= S_DIG;
          end
        end
        S_DIG: begin
          rd_idx_r <= rd_idx_r - 1'b1;
          if (rd_idx_r == '0) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_is_last = out_last_r;

endmodule

// ===== hw/rtl/fmtu_div.sv =====
// Iterative divider of a value by a small base, DIV_BITS quotient bits per cycle.
// Depends on fmtu_pkg.
module fmtu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fmtu_pkg::div_req_t req,
  output fmtu_pkg::div_rsp_t rsp
);
  import fmtu_pkg::*;

  logic [QW-1:0]     quo_r;
  logic [QW-1:0]     quo_nxt;
  logic [3:0]        rem_r;
  logic [3:0]        rem_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [QW-1:0]     q_w;
  logic [4:0]        r_w;

  always_comb begin
    q_w = quo_r;
    r_w = {1'b0, rem_r};
    for (int i = 0; i < DIV_BITS; i++) begin
      r_w = {r_w[3:0], q_w[QW-1]};
      q_w = {q_w[QW-2:0], 1'b0};
      if (r_w >= req.divisor) begin
        r_w    = r_w - req.divisor;
        q_w[0] = 1'b1;
      end
    end
    quo_nxt = q_w;
    rem_nxt = r_w[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= QW'(req.dividend);
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[VALUE_WIDTH-1:0];
  assign rsp.rem      = rem_r;

endmodule

// ===== hw/rtl/fmtu_chk.sv =====
// Port-level checker for the radix text formatter and its bind to the top level.
// Depends only on the top level's ports.
module fmtu_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_is_last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted beat");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_is_last |-> out_valid)
    else $error("last flag without a beat");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |=> !out_valid)
    else $error("beat right after the last character");

  a_idle_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_is_last)
    else $error("busy dropped without the last character");

endmodule

bind format_unsigned_in_base_padded fmtu_chk u_fmtu_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_is_last (out_is_last)
);
